### src/ppc_pkg.sv
// Shared types, pattern tables and decode helpers for the payload protocol classifier.
// Used by ppc_scan, ppc_verdict and payload_protocol_classifier; no dependencies.
package ppc_pkg;

   typedef enum logic [2:0] {
      PROTO_UNKNOWN  = 3'd0,
      PROTO_HTTP     = 3'd1,
      PROTO_IRC      = 3'd2,
      PROTO_FTP      = 3'd3,
      PROTO_SMTP     = 3'd4,
      PROTO_FDATA    = 3'd5,
      PROTO_SSL      = 3'd6
   } proto_type;

   localparam logic [2:0] TLS_NONE  = 3'd0;
   localparam logic [2:0] TLS_OTHER = 3'd5;
   localparam logic [3:0] HS_NONE   = 4'd0;

   localparam logic [7:0] REC_HANDSHAKE   = 8'h16;
   localparam logic [7:0] REC_APP_DATA    = 8'h17;
   localparam logic [7:0] SSL_MAJOR       = 8'h03;
   localparam logic [7:0] V2_CLIENT_HELLO = 8'h01;

   localparam int HEAD_DEPTH = 6;

   // Bit positions in the found flags and prefix flags.
   localparam int FOUND_HTTP    = 0;
   localparam int FOUND_FTP     = 1;
   localparam int FOUND_WELCOME = 2;
   localparam int PFX_NICK      = 0;
   localparam int PFX_FDAT      = 1;
   localparam int PFX_220       = 2;

   localparam logic [7:0] PAT_HTTP [5] = '{"H", "T", "T", "P", "/"};
   localparam logic [7:0] PAT_NICK [5] = '{"N", "I", "C", "K", " "};
   localparam logic [7:0] PAT_FDAT [8] = '{"F", "T", "P", "_", "d", "a", "t", "a"};
   localparam logic [7:0] PAT_220  [3] = '{"2", "2", "0"};
   localparam logic [7:0] PAT_FTP  [3] = '{"f", "t", "p"};
   localparam logic [7:0] PAT_WELC [7] = '{"w", "e", "l", "c", "o", "m", "e"};

   // Snapshot of the scan state including the byte just taken.
   typedef struct packed {
      logic [3:0]                 pos;
      logic [HEAD_DEPTH-1:0][7:0] head;
      logic [2:0]                 prefix;
      logic [2:0]                 found;
   } scan_view_type;

   typedef struct packed {
      logic       sslv2_hello;
      logic [3:0] handshake_type;
      logic [2:0] tls_version;
      proto_type  protocol;
   } verdict_type;

   function automatic logic [7:0] fold_case(input logic [7:0] b);
      if (b >= "A" && b <= "Z") begin
         return b | 8'h20;
      end
      return b;
   endfunction

   function automatic logic [2:0] tls_ver(input logic [7:0] major, input logic [7:0] minor);
      if (major == SSL_MAJOR && minor <= 8'd3) begin
         return minor[2:0] + 3'd1;
      end
      return TLS_OTHER;
   endfunction

   function automatic logic [3:0] hs_code(input logic [7:0] t);
      logic [3:0] r;
      unique case (t)
         8'h00:   r = 4'd1;
         8'h01:   r = 4'd2;
         8'h02:   r = 4'd3;
         8'h0b:   r = 4'd4;
         8'h0c:   r = 4'd5;
         8'h0d:   r = 4'd6;
         8'h0e:   r = 4'd7;
         8'h0f:   r = 4'd8;
         8'hf0:   r = 4'd9;
         8'hf4:   r = 4'd10;
         default: r = HS_NONE;
      endcase
      return r;
   endfunction

endpackage

### src/payload_protocol_classifier.sv
// Payload protocol classifier: one verdict per payload, issued on its last byte.
// The last byte passes through the input register; its verdict is then registered in the
// result register, which raises rsp_tvalid; an untaken verdict stalls the last byte.
// Throughput: one byte per cycle; a last byte waits in the input register while the
// result register still holds an untaken verdict. Reset (synchronous, active high)
// clears both pipeline stages and the scan state. Depends on ppc_pkg, ppc_scan, ppc_verdict.
module payload_protocol_classifier import ppc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   input  logic        req_tuser,   // passive_hit
   // Verdict stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [2:0] protocol, [5:3] tls_version,
                                    // [9:6] handshake_type, [10] sslv2_hello, rest zero
);

   // Input register: one byte waiting to be scanned.
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;
   logic        s1_passive_ff;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type rsp_data_ff;

   logic          out_free;
   logic          s1_go;
   logic          req_take;
   scan_view_type view;
   verdict_type   verdict;

   // A non-final byte needs no output slot, so it always drains; a final
   // byte moves only when the result register is empty or being emptied.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_go);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   ppc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_go),
      .last      (s1_last_ff),
      .data_byte (s1_byte_ff),
      .view      (view)
   );

   ppc_verdict u_verdict (
      .view        (view),
      .passive_hit (s1_passive_ff),
      .verdict     (verdict)
   );

   // Hold control state under reset; payload registers load on transactions only.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         s1_byte_ff    <= req_tdata;
         s1_last_ff    <= req_tlast;
         s1_passive_ff <= req_tuser;
      end
      if (s1_go && s1_last_ff) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

endmodule

### src/ppc_scan.sv
// Per-byte scan state: position, header bytes, prefix checks and substring matchers.
// Depends on ppc_pkg.
module ppc_scan import ppc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic          last,
   input  logic [7:0]    data_byte,
   output scan_view_type view
);

   logic [3:0]                 pos_ff, pos_in;
   logic [HEAD_DEPTH-1:0][7:0] head_ff, head_in;
   logic                       nul_ff, nul_in;
   logic [2:0]                 prefix_ff, prefix_in;
   logic [2:0]                 http_ff, http_in;
   logic [1:0]                 ftp_ff, ftp_in;
   logic [2:0]                 welc_ff, welc_in;
   logic [2:0]                 found_ff, found_in;
   logic [7:0]                 lb;

   always_comb begin
      pos_in    = pos_ff;
      head_in   = head_ff;
      nul_in    = nul_ff;
      prefix_in = prefix_ff;
      http_in   = http_ff;
      ftp_in    = ftp_ff;
      welc_in   = welc_ff;
      found_in  = found_ff;
      lb        = fold_case(data_byte);

      // Substring search stops at the first NUL.
      if (!nul_ff) begin
         if (data_byte == 8'h00) begin
            nul_in = 1'b1;
         end else begin
            if (data_byte == PAT_HTTP[http_ff]) begin
               if (http_ff == 3'd4) begin
                  found_in[FOUND_HTTP] = 1'b1;
                  http_in              = 3'd0;
               end else begin
                  http_in = http_ff + 3'd1;
               end
            end else if (data_byte == PAT_HTTP[0]) begin
               http_in = 3'd1;
            end else begin
               http_in = 3'd0;
            end

            if (lb == PAT_FTP[ftp_ff]) begin
               if (ftp_ff == 2'd2) begin
                  found_in[FOUND_FTP] = 1'b1;
                  ftp_in              = 2'd0;
               end else begin
                  ftp_in = ftp_ff + 2'd1;
               end
            end else if (lb == PAT_FTP[0]) begin
               ftp_in = 2'd1;
            end else begin
               ftp_in = 2'd0;
            end

            if (lb == PAT_WELC[welc_ff]) begin
               if (welc_ff == 3'd6) begin
                  found_in[FOUND_WELCOME] = 1'b1;
                  welc_in                 = 3'd0;
               end else begin
                  welc_in = welc_ff + 3'd1;
               end
            end else if (lb == PAT_WELC[0]) begin
               welc_in = 3'd1;
            end else begin
               welc_in = 3'd0;
            end
         end
      end

      if (pos_ff < 4'd6) begin
         head_in[pos_ff[2:0]] = data_byte;
      end
      if (pos_ff < 4'd5) begin
         if (data_byte != PAT_NICK[pos_ff[2:0]]) prefix_in[PFX_NICK] = 1'b0;
      end
      if (pos_ff < 4'd8) begin
         if (data_byte != PAT_FDAT[pos_ff[2:0]]) prefix_in[PFX_FDAT] = 1'b0;
      end
      if (pos_ff < 4'd3) begin
         if (data_byte != PAT_220[pos_ff[1:0]]) prefix_in[PFX_220] = 1'b0;
      end
      if (pos_ff != 4'hF) begin
         pos_in = pos_ff + 4'd1;
      end
   end

   assign view = '{pos: pos_in, head: head_in, prefix: prefix_in, found: found_in};

   // Clear everything on reset and after the verdict byte.
   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         pos_ff    <= '0;
         head_ff   <= '0;
         nul_ff    <= 1'b0;
         prefix_ff <= '1;
         http_ff   <= '0;
         ftp_ff    <= '0;
         welc_ff   <= '0;
         found_ff  <= '0;
      end else if (step) begin
         pos_ff    <= pos_in;
         head_ff   <= head_in;
         nul_ff    <= nul_in;
         prefix_ff <= prefix_in;
         http_ff   <= http_in;
         ftp_ff    <= ftp_in;
         welc_ff   <= welc_in;
         found_ff  <= found_in;
      end
   end

endmodule

### src/ppc_verdict.sv
// Priority decode of the scan snapshot into a protocol verdict.
// Depends on ppc_pkg.
module ppc_verdict import ppc_pkg::*; (
   input  scan_view_type view,
   input  logic          passive_hit,
   output verdict_type   verdict
);

   logic nick_ok, fdat_ok, p220_ok;

   assign nick_ok = view.prefix[PFX_NICK] && (view.pos >= 4'd5);
   assign fdat_ok = view.prefix[PFX_FDAT] && (view.pos >= 4'd8);
   assign p220_ok = view.prefix[PFX_220]  && (view.pos >= 4'd3);

   always_comb begin
      verdict.protocol       = PROTO_UNKNOWN;
      verdict.tls_version    = TLS_NONE;
      verdict.handshake_type = HS_NONE;
      verdict.sslv2_hello    = 1'b0;
      priority if (view.found[FOUND_HTTP]) begin
         verdict.protocol = PROTO_HTTP;
      end else if (nick_ok) begin
         verdict.protocol = PROTO_IRC;
      end else if (fdat_ok) begin
         verdict.protocol = PROTO_FDATA;
      end else if (p220_ok) begin
         verdict.protocol = (view.found[FOUND_FTP] || view.found[FOUND_WELCOME]) ?
                            PROTO_FTP : PROTO_SMTP;
      end else if (view.head[0] == REC_HANDSHAKE) begin
         verdict.protocol       = PROTO_SSL;
         verdict.tls_version    = tls_ver(view.head[1], view.head[2]);
         verdict.handshake_type = hs_code(view.head[5]);
      end else if (view.head[0] != REC_APP_DATA && view.head[2] == V2_CLIENT_HELLO) begin
         verdict.protocol    = PROTO_SSL;
         verdict.sslv2_hello = 1'b1;
         if (view.head[3] == SSL_MAJOR && view.head[4] <= 8'd3) begin
            verdict.tls_version = view.head[4][2:0] + 3'd1;
         end
      end else begin
         verdict.protocol = passive_hit ? PROTO_FDATA : PROTO_UNKNOWN;
      end
   end

endmodule
